### rtl/pcaqi_pkg.sv
// Package: widths, segment coefficients and shared types for the particle AQI block.
`timescale 1ns / 1ps

package pcaqi_pkg;

  localparam int unsigned ConcW    = 14;
  localparam int unsigned AqiW     = 10;
  localparam int unsigned CatW     = 3;
  localparam int unsigned DiffW    = 13;
  localparam int unsigned KW       = 19;
  localparam int unsigned BW       = 20;
  localparam int unsigned FracW    = 20;
  localparam int unsigned AccW     = 30;
  localparam int unsigned SegCount = 7;

  localparam logic [ConcW-1:0] ConcTop = 14'd10000;
  localparam logic [AqiW-1:0]  AqiTop  = 10'd725;
  localparam logic [AqiW-1:0]  AqiGood = 10'd50;

  typedef logic [CatW-1:0] seg_idx_t;

  localparam seg_idx_t SegGood = 3'd0;
  localparam seg_idx_t SegLast = 3'd6;

  // q = (d * k + b) >> FracW equals floor((a*d + c0) / c) for the segment, with
  // k = a*M, b = c0*M, M = ceil(2^FracW / c).
  typedef struct packed {
    logic [ConcW-1:0] c_lo;
    logic [AqiW-1:0]  i_lo;
    logic [KW-1:0]    k;
    logic [BW-1:0]    b;
  } seg_coef_t;

  typedef struct packed {
    seg_idx_t         idx;
    logic [DiffW-1:0] diff;
  } seg_pick_t;

  function automatic seg_coef_t seg_coef(input seg_idx_t idx);
    seg_coef_t c;
    unique case (idx)
      3'd0:    c = '{c_lo: 14'd0,    i_lo: 10'd0,   k: 19'd436910, b: 20'd524292};
      3'd1:    c = '{c_lo: 14'd120,  i_lo: 10'd50,  k: 19'd223120, b: 20'd524332};
      3'd2:    c = '{c_lo: 14'd355,  i_lo: 10'd100, k: 19'd262144, b: 20'd524288};
      3'd3:    c = '{c_lo: 14'd555,  i_lo: 10'd150, k: 19'd55190,  b: 20'd524305};
      3'd4:    c = '{c_lo: 14'd1505, i_lo: 10'd200, k: 19'd104858, b: 20'd524290};
      3'd5:    c = '{c_lo: 14'd2505, i_lo: 10'd300, k: 19'd104858, b: 20'd524290};
      3'd6:    c = '{c_lo: 14'd3505, i_lo: 10'd400, k: 19'd52429,  b: 20'd524290};
      default: c = '{c_lo: 14'd0,    i_lo: 10'd0,   k: 19'd436910, b: 20'd524292};
    endcase
    return c;
  endfunction

endpackage

### rtl/pcaqi_seg_sel.sv
// Clamp and segment select: finds the segment and the offset into it.
`timescale 1ns / 1ps

module pcaqi_seg_sel (
  input  logic [pcaqi_pkg::ConcW-1:0] conc_i,
  output pcaqi_pkg::seg_pick_t        pick_o
);
  import pcaqi_pkg::*;

  logic [ConcW-1:0] conc_clamped;
  logic [ConcW-1:0] offset;
  seg_idx_t         idx;

  assign conc_clamped = (conc_i > ConcTop) ? ConcTop : conc_i;

  always_comb begin
    idx = SegGood;
    for (int unsigned k = 1; k < SegCount; k++) begin
      if (conc_clamped >= seg_coef(seg_idx_t'(k)).c_lo) begin
        idx = seg_idx_t'(k);
      end
    end
  end

  assign offset      = conc_clamped - seg_coef(idx).c_lo;
  assign pick_o.idx  = idx;
  assign pick_o.diff = offset[DiffW-1:0];

endmodule

### rtl/pcaqi_interp.sv
// Interpolation: scaled multiply, rounding constant and segment base index.
`timescale 1ns / 1ps

module pcaqi_interp (
  input  pcaqi_pkg::seg_pick_t       pick_i,
  output logic [pcaqi_pkg::AqiW-1:0] aqi_o,
  output logic [pcaqi_pkg::CatW-1:0] category_o
);
  import pcaqi_pkg::*;

  seg_coef_t              coef;
  logic [DiffW+KW-1:0]    prod;
  logic [AccW-1:0]        acc;

  assign coef       = seg_coef(pick_i.idx);
  assign prod       = (DiffW+KW)'(pick_i.diff) * (DiffW+KW)'(coef.k);
  assign acc        = AccW'(prod) + AccW'(coef.b);
  assign aqi_o      = coef.i_lo + acc[AccW-1:FracW];
  assign category_o = pick_i.idx;

endmodule

### rtl/particle_concentration_to_aqi.sv
// Top level: input register, segment select and interpolation, result register.
`timescale 1ns / 1ps

// Converts a particle concentration in tenths of a unit (clamped at 1000.0)
// into an air quality index, rounded half up, and a category code 0..6. One
// beat is accepted per cycle unless an output stall backs up to the input;
// each beat passes through the input register and then the result register;
// the path between the two is set by one 13x19 constant-coefficient multiply
// and a 30-bit add. No configuration, no state between beats; stalls on the
// output back up through both registers.

module particle_concentration_to_aqi (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcaqi_pkg::ConcW-1:0]   concentration_tenths_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcaqi_pkg::AqiW-1:0]    aqi_o,
  output logic [pcaqi_pkg::CatW-1:0]    category_o
);
  import pcaqi_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [ConcW-1:0] conc_q;
  logic             out_valid_q, out_valid_d;
  logic [AqiW-1:0]  aqi_q;
  logic [CatW-1:0]  cat_q;
  logic             s1_ready, s2_ready;
  seg_pick_t        pick;
  logic [AqiW-1:0]  aqi_calc;
  logic [CatW-1:0]  cat_calc;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      conc_q <= concentration_tenths_i;
    end
    if (s1_valid_q && s2_ready) begin
      aqi_q <= aqi_calc;
      cat_q <= cat_calc;
    end
  end

  pcaqi_seg_sel u_seg_sel (
    .conc_i (conc_q),
    .pick_o (pick)
  );

  pcaqi_interp u_interp (
    .pick_i     (pick),
    .aqi_o      (aqi_calc),
    .category_o (cat_calc)
  );

  assign out_valid_o = out_valid_q;
  assign aqi_o       = aqi_q;
  assign category_o  = cat_q;

  a_cat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> category_o <= SegLast)
    else $error("category out of range");

  a_aqi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> aqi_o <= AqiTop)
    else $error("aqi above top");

  a_good_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && category_o == SegGood) |-> aqi_o <= AqiGood)
    else $error("good category with high aqi");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(conc_q)))
    else $error("input stage lost a held beat");

  a_s1_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> out_valid_q)
    else $error("beat not moved to result register");

endmodule
